@@ src/line_rasterizer_unit_assert.svh @@
// assertion macros for the line rasteriser checker
// each macro expects i_clk and i_rst_n in the scope where it is used
`ifndef LINE_RASTERIZER_UNIT_ASSERT_SVH
`define LINE_RASTERIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define LRU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LRU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/lr_pkg.sv @@
// shared types and constants of the line rasteriser
// no dependencies
package lr_pkg;

    localparam int COORD_W   = 13;
    localparam int SPAN_W    = 13;
    localparam int SPAN2_W   = 15;
    localparam int ERR_W     = 16;
    localparam int COLOR_W   = 32;
    localparam int FRAME_W   = 12;

    localparam int S_FIELDS_W = 4 * COORD_W + COLOR_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_PAD_W    = S_TDATA_W - S_FIELDS_W;
    localparam int M_FIELDS_W = 2 * COORD_W + COLOR_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    localparam int DEF_FRAME_WIDTH  = 1024;
    localparam int DEF_FRAME_HEIGHT = 1024;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [COLOR_W-1:0]        t_color;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } t_command;

    typedef struct packed {
        t_coord                    major_pos;
        t_coord                    major_stop;
        t_coord                    minor_pos;
        logic signed [ERR_W-1:0]   error_term;
        logic [SPAN2_W-1:0]        twice_major_span;
        logic [SPAN2_W-1:0]        twice_minor_span;
        logic                      axes_swapped;
        logic                      minor_decrements;
        logic                      busy;
    } t_line_setup;

endpackage

@@ src/lr_setup.sv @@
// line set-up: steepness test, axis swap, endpoint ordering and error term init
// depends on lr_pkg
module lr_setup (
    input  lr_pkg::t_coord      i_start_x,
    input  lr_pkg::t_coord      i_start_y,
    input  lr_pkg::t_coord      i_end_x,
    input  lr_pkg::t_coord      i_end_y,
    output lr_pkg::t_line_setup o_setup
);

    logic signed [lr_pkg::COORD_W:0] dx, dy;
    logic [lr_pkg::SPAN_W-1:0]       adx, ady, maj_span, min_span;
    logic                            steep, reorder;
    lr_pkg::t_coord                  a_maj, a_min, b_maj, b_min;
    lr_pkg::t_coord                  lo_maj, lo_min, hi_maj, hi_min;

    always_comb begin
        dx = (lr_pkg::COORD_W+1)'(i_end_x) - (lr_pkg::COORD_W+1)'(i_start_x);
        dy = (lr_pkg::COORD_W+1)'(i_end_y) - (lr_pkg::COORD_W+1)'(i_start_y);
        adx = dx[lr_pkg::COORD_W] ? lr_pkg::SPAN_W'(-dx) : dx[lr_pkg::SPAN_W-1:0];
        ady = dy[lr_pkg::COORD_W] ? lr_pkg::SPAN_W'(-dy) : dy[lr_pkg::SPAN_W-1:0];
        steep = ady > adx;

        a_maj = steep ? i_start_y : i_start_x;
        a_min = steep ? i_start_x : i_start_y;
        b_maj = steep ? i_end_y   : i_end_x;
        b_min = steep ? i_end_x   : i_end_y;

        // walk always runs towards the larger major coordinate
        reorder = a_maj > b_maj;
        lo_maj  = reorder ? b_maj : a_maj;
        lo_min  = reorder ? b_min : a_min;
        hi_maj  = reorder ? a_maj : b_maj;
        hi_min  = reorder ? a_min : b_min;

        // spans are unchanged by the reorder, so reuse the magnitudes
        maj_span = steep ? ady : adx;
        min_span = steep ? adx : ady;

        o_setup.major_pos        = lo_maj;
        o_setup.major_stop       = hi_maj;
        o_setup.minor_pos        = lo_min;
        o_setup.error_term       = signed'(lr_pkg::ERR_W'(maj_span));
        o_setup.twice_major_span = {1'b0, maj_span, 1'b0};
        o_setup.twice_minor_span = {1'b0, min_span, 1'b0};
        o_setup.axes_swapped     = steep;
        o_setup.minor_decrements = !(lo_min < hi_min);
        o_setup.busy             = maj_span != '0;
    end

endmodule

@@ src/line_rasterizer_unit.sv @@
// top level of the line rasteriser: line state, step datapath and output register
// depends on lr_pkg and lr_setup
//
// A start transfer (tuser = 0) loads a line and gives no pixel; each step
// transfer (tuser = 1) on a loaded line gives exactly one pixel, walking the
// major axis from the endpoint with the smaller major coordinate up to but not
// including the other, with tlast on the final one. A step on an idle or zero-length line gives nothing.
// One transfer is taken every clock while s_axis_tready is high: a step updates the
// line registers and loads its pixel into the output register at the same clock edge.
// s_axis_tready drops only while a pixel sits in the output register and the
// downstream side is not taking it.
module line_rasterizer_unit #(
    parameter int FRAME_WIDTH  = lr_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = lr_pkg::DEF_FRAME_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // start_x, start_y, end_x, end_y, paint, zero fill
    input  logic [lr_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // command
    input  logic [0:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // pixel_x, pixel_y, pixel_color, zero fill
    output logic [lr_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // inside_frame
    output logic [0:0]                    m_axis_tuser,
    output logic                          m_axis_tlast
);

    localparam logic [lr_pkg::FRAME_W-1:0] FW = lr_pkg::FRAME_W'(FRAME_WIDTH);
    localparam logic [lr_pkg::FRAME_W-1:0] FH = lr_pkg::FRAME_W'(FRAME_HEIGHT);
    localparam int CW = lr_pkg::COORD_W;

    lr_pkg::t_coord                 in_start_x, in_start_y, in_end_x, in_end_y;
    lr_pkg::t_color                 in_paint;
    lr_pkg::t_line_setup            setup;

    logic                           r_busy;
    lr_pkg::t_coord                 r_major_pos, r_major_stop, r_minor_pos;
    logic signed [lr_pkg::ERR_W-1:0] r_error;
    logic [lr_pkg::SPAN2_W-1:0]     r_twice_major, r_twice_minor;
    logic                           r_swapped, r_minor_dec;
    lr_pkg::t_color                 r_color;

    logic                           r_out_valid;
    lr_pkg::t_coord                 r_out_x, r_out_y;
    lr_pkg::t_color                 r_out_color;
    logic                           r_out_inside, r_out_last;

    logic                           s_fire, is_start, do_step;
    lr_pkg::t_coord                 px, py;
    logic                           in_frame, fin;
    logic signed [CW:0]             major_next;
    logic [lr_pkg::ERR_W:0]         err_sub, err_add;
    lr_pkg::t_coord                 n_minor_pos;
    logic signed [lr_pkg::ERR_W-1:0] n_error;

    assign in_start_x = s_axis_tdata[CW-1:0];
    assign in_start_y = s_axis_tdata[2*CW-1:CW];
    assign in_end_x   = s_axis_tdata[3*CW-1:2*CW];
    assign in_end_y   = s_axis_tdata[4*CW-1:3*CW];
    assign in_paint   = s_axis_tdata[4*CW+lr_pkg::COLOR_W-1:4*CW];

    lr_setup u_setup (
        .i_start_x (in_start_x),
        .i_start_y (in_start_y),
        .i_end_x   (in_end_x),
        .i_end_y   (in_end_y),
        .o_setup   (setup)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign is_start      = lr_pkg::t_command'(s_axis_tuser[0]) == lr_pkg::CMD_START;
    assign do_step       = s_fire && !is_start && r_busy;

    always_comb begin
        px = r_swapped ? r_minor_pos : r_major_pos;
        py = r_swapped ? r_major_pos : r_minor_pos;
        in_frame = !px[CW-1] && !py[CW-1] &&
                   (px[lr_pkg::FRAME_W-1:0] < FW) && (py[lr_pkg::FRAME_W-1:0] < FH);
        major_next = (CW+1)'(r_major_pos) + (CW+1)'(1);
        fin = major_next >= (CW+1)'(r_major_stop);

        // error at twice the scale: subtract, then add back when it goes negative
        err_sub = {r_error[lr_pkg::ERR_W-1], r_error}
                  - (lr_pkg::ERR_W+1)'(r_twice_minor);
        err_add = err_sub + (lr_pkg::ERR_W+1)'(r_twice_major);
        if (err_sub[lr_pkg::ERR_W]) begin
            n_error     = signed'(err_add[lr_pkg::ERR_W-1:0]);
            n_minor_pos = r_minor_dec ? r_minor_pos - CW'(1) : r_minor_pos + CW'(1);
        end else begin
            n_error     = signed'(err_sub[lr_pkg::ERR_W-1:0]);
            n_minor_pos = r_minor_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_fire && is_start) begin
                r_busy <= setup.busy;
            end else if (do_step) begin
                r_busy <= !fin;
            end

            if (do_step) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire && is_start) begin
            r_major_pos   <= setup.major_pos;
            r_major_stop  <= setup.major_stop;
            r_minor_pos   <= setup.minor_pos;
            r_error       <= setup.error_term;
            r_twice_major <= setup.twice_major_span;
            r_twice_minor <= setup.twice_minor_span;
            r_swapped     <= setup.axes_swapped;
            r_minor_dec   <= setup.minor_decrements;
            r_color       <= in_paint;
        end else if (do_step) begin
            r_major_pos <= major_next[CW-1:0];
            r_minor_pos <= n_minor_pos;
            r_error     <= n_error;
        end

        if (do_step) begin
            r_out_x      <= px;
            r_out_y      <= py;
            r_out_color  <= r_color;
            r_out_inside <= in_frame;
            r_out_last   <= fin;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{lr_pkg::M_PAD_W{1'b0}}, r_out_color, r_out_y, r_out_x};
    assign m_axis_tuser  = r_out_inside;
    assign m_axis_tlast  = r_out_last;

endmodule

@@ src/lr_checker.sv @@
// port-level checks on the line rasteriser, attached by bind
// depends on lr_pkg and line_rasterizer_unit_assert.svh
`include "line_rasterizer_unit_assert.svh"

module lr_checker #(
    parameter int FRAME_WIDTH  = lr_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = lr_pkg::DEF_FRAME_HEIGHT
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [0:0]                    s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [lr_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic [0:0]                    m_axis_tuser,
    input logic                          m_axis_tlast
);

    localparam int CW = lr_pkg::COORD_W;
    localparam logic [lr_pkg::FRAME_W-1:0] FW = lr_pkg::FRAME_W'(FRAME_WIDTH);
    localparam logic [lr_pkg::FRAME_W-1:0] FH = lr_pkg::FRAME_W'(FRAME_HEIGHT);

    logic step_fire, frame_ok;

    assign step_fire = s_axis_tvalid && s_axis_tready &&
                       (lr_pkg::t_command'(s_axis_tuser[0]) == lr_pkg::CMD_STEP);
    assign frame_ok  = !m_axis_tdata[CW-1] && !m_axis_tdata[2*CW-1] &&
                       (m_axis_tdata[lr_pkg::FRAME_W-1:0] < FW) &&
                       (m_axis_tdata[CW+lr_pkg::FRAME_W-1:CW] < FH);

    // stalled pixel holds
    `LRU_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "pixel changed while stalled")

    // an empty output register never blocks the input side
    `LRU_ASSERT_NOW(a_no_bubble, !m_axis_tvalid, s_axis_tready,
        "input stalled with no pixel pending")

    // every fresh pixel comes from a step transfer in the previous cycle
    `LRU_ASSERT_NOW(a_pixel_from_step,
        m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready), $past(step_fire),
        "pixel without a step transfer")

    // frame flag agrees with the coordinates shown
    `LRU_ASSERT_NOW(a_frame_flag, m_axis_tvalid, m_axis_tuser[0] == frame_ok,
        "inside_frame flag disagrees with coordinates")

endmodule

bind line_rasterizer_unit lr_checker #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
) u_lr_checker (.*);
